@@ src/protobuf_field_decoder_assert.svh @@
// Assertion macros for the protobuf field decoder checker.
// Needs nothing but a clock and an active-low reset at the place of use.
`ifndef PROTOBUF_FIELD_DECODER_ASSERT_SVH
`define PROTOBUF_FIELD_DECODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define PFD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("protobuf_field_decoder: assertion failed");

// Next-cycle implication, disabled while reset is low.
`define PFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("protobuf_field_decoder: assertion failed");

`endif

@@ src/pfd_pkg.sv @@
// Shared types and constants of the protobuf field decoder.
// Used by every module of the block; depends on nothing.
package pfd_pkg;

  localparam int unsigned FieldWidth            = 61;
  localparam int unsigned ValueWidth            = 64;
  localparam int unsigned LengthBitsDefault     = 32;
  localparam int unsigned MaxVarintBytesDefault = 10;
  localparam int unsigned QueueDepth            = 2;

  typedef enum logic [2:0] {
    KIND_NONE   = 3'd0,
    KIND_VARINT = 3'd1,
    KIND_BYTE   = 3'd2,
    KIND_EMPTY  = 3'd3,
    KIND_WIRE   = 3'd4,
    KIND_TRUNC  = 3'd5
  } kind_e;

  // Wire type codes that the decoder accepts.
  localparam logic [2:0] WireVarint = 3'd0;
  localparam logic [2:0] WireLength = 3'd2;

  // One input byte after classification by the front stage.
  typedef struct packed {
    logic [6:0] data;
    logic       cont;
    logic       last;
  } item_t;

endpackage

@@ src/protobuf_field_decoder.sv @@
// Protobuf field decoder. Takes one message byte per cycle on a valid/ready
// channel and sustains one byte per cycle while out_ready_i is held high,
// with each byte producing at most one result item. A byte's result goes
// through the front register, the two-entry queue and the output register.
// The rate is set by the decoder's varint step, which takes a byte at a time.
// Results are varint fields, payload bytes of length-delimited fields tagged
// with their field number, empty-field markers and error codes; the item for
// the byte flagged last always carries message_end. Depends on pfd_pkg.
module protobuf_field_decoder #(
  parameter int unsigned LengthBits     = pfd_pkg::LengthBitsDefault,
  parameter int unsigned MaxVarintBytes = pfd_pkg::MaxVarintBytesDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [7:0]                     in_byte_i,
  input  logic                           last_byte_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  output logic [2:0]                     kind_o,
  output logic [pfd_pkg::FieldWidth-1:0] field_number_o,
  output logic [pfd_pkg::ValueWidth-1:0] field_value_o,
  output logic                           payload_last_o,
  output logic                           message_end_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i
);
  import pfd_pkg::*;

  item_t front_item, queue_item;
  logic  front_valid, front_ready;
  logic  queue_valid, queue_ready;

  pfd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_byte_i    (in_byte_i),
    .last_byte_i  (last_byte_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .item_o       (front_item),
    .item_valid_o (front_valid),
    .item_ready_i (front_ready)
  );

  pfd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_item_i  (front_item),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .pop_item_o   (queue_item),
    .pop_valid_o  (queue_valid),
    .pop_ready_i  (queue_ready)
  );

  pfd_back #(
    .LengthBits     (LengthBits),
    .MaxVarintBytes (MaxVarintBytes)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_i         (queue_item),
    .item_valid_i   (queue_valid),
    .item_ready_o   (queue_ready),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .kind_o         (kind_o),
    .field_number_o (field_number_o),
    .field_value_o  (field_value_o),
    .payload_last_o (payload_last_o),
    .message_end_o  (message_end_o)
  );

endmodule

@@ src/pfd_front.sv @@
// Front stage: accepts input bytes and splits them into varint data bits,
// continuation flag and end-of-message flag. Depends on pfd_pkg.
module pfd_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [7:0]    in_byte_i,
  input  logic          last_byte_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output pfd_pkg::item_t item_o,
  output logic          item_valid_o,
  input  logic          item_ready_i
);
  import pfd_pkg::*;

  item_t item_q;
  logic  valid_q;

  assign in_ready_o   = !valid_q || item_ready_i;
  assign item_o       = item_q;
  assign item_valid_o = valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      valid_q <= 1'b1;
    end else if (item_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.data <= in_byte_i[6:0];
      item_q.cont <= in_byte_i[7];
      item_q.last <= last_byte_i;
    end
  end

endmodule

@@ src/pfd_queue.sv @@
// Short queue between the front stage and the decoder.
// Depends on pfd_pkg for the item type and the depth.
module pfd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  pfd_pkg::item_t push_item_i,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  output pfd_pkg::item_t pop_item_o,
  output logic           pop_valid_o,
  input  logic           pop_ready_i
);
  import pfd_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  item_t            mem_q [QueueDepth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;
  logic             push, pop;

  assign push_ready_o = count_q != CntW'(QueueDepth);
  assign pop_valid_o  = count_q != '0;
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

@@ src/pfd_back.sv @@
// Decoder back end: varint assembly, field state machine and the output
// register. Depends on pfd_pkg.
module pfd_back #(
  parameter int unsigned LengthBits     = pfd_pkg::LengthBitsDefault,
  parameter int unsigned MaxVarintBytes = pfd_pkg::MaxVarintBytesDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  pfd_pkg::item_t                   item_i,
  input  logic                             item_valid_i,
  output logic                             item_ready_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [2:0]                       kind_o,
  output logic [pfd_pkg::FieldWidth-1:0]   field_number_o,
  output logic [pfd_pkg::ValueWidth-1:0]   field_value_o,
  output logic                             payload_last_o,
  output logic                             message_end_o
);
  import pfd_pkg::*;

  localparam int unsigned CntW = $clog2(MaxVarintBytes);
  localparam logic [ValueWidth-1:0] LenMask =
      (LengthBits >= ValueWidth) ? '1 : ((64'd1 << LengthBits) - 64'd1);

  typedef enum logic [1:0] {
    PH_TAG,
    PH_VALUE,
    PH_LENGTH,
    PH_PAYLOAD
  } phase_e;

  phase_e                  phase_q, phase_d;
  logic [CntW-1:0]         cnt_q, cnt_d;
  logic [ValueWidth-1:0]   acc_q, acc_d;
  logic [FieldWidth-1:0]   field_q, field_d;
  logic [LengthBits-1:0]   rem_q, rem_d;
  logic                    halted_q, halted_d;

  logic                    out_valid_q;
  kind_e                   kind_q;
  logic [FieldWidth-1:0]   fnum_q;
  logic [ValueWidth-1:0]   value_q;
  logic                    plast_q, end_q;

  logic                    res_valid;
  kind_e                   res_kind;
  logic [FieldWidth-1:0]   res_fnum;
  logic [ValueWidth-1:0]   res_value;
  logic                    res_plast, res_end;

  logic [5:0]              shamt;
  logic [ValueWidth-1:0]   acc_new;
  logic                    overlong;
  logic                    pop;

  assign item_ready_o = !out_valid_q || out_ready_i;
  assign pop          = item_valid_i && item_ready_o;

  // Bit position of this byte's seven data bits; the last possible byte
  // lands at bit 63 and keeps only its lowest data bit.
  assign shamt    = 6'(32'(cnt_q) * 7);
  assign acc_new  = acc_q | (ValueWidth'(item_i.data) << shamt);
  assign overlong = item_i.cont && ((32'(cnt_q) + 32'd1) >= MaxVarintBytes);

  always_comb begin
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    acc_d     = acc_q;
    field_d   = field_q;
    rem_d     = rem_q;
    halted_d  = halted_q;
    res_valid = 1'b0;
    res_kind  = KIND_NONE;
    res_fnum  = '0;
    res_value = '0;
    res_plast = 1'b0;
    res_end   = 1'b0;

    if (!halted_q) begin
      if (phase_q == PH_PAYLOAD) begin
        rem_d     = rem_q - 1'b1;
        res_valid = 1'b1;
        res_kind  = KIND_BYTE;
        res_fnum  = field_q;
        res_value = ValueWidth'({item_i.cont, item_i.data});
        res_plast = rem_q == LengthBits'(1);
        if (res_plast) begin
          phase_d = PH_TAG;
        end
      end else if (item_i.cont) begin
        if (overlong) begin
          res_valid = 1'b1;
          res_kind  = KIND_TRUNC;
          res_fnum  = (phase_q == PH_TAG) ? '0 : field_q;
          halted_d  = 1'b1;
        end else begin
          cnt_d = cnt_q + 1'b1;
          acc_d = acc_new;
        end
      end else begin
        cnt_d = '0;
        acc_d = '0;
        unique case (phase_q)
          PH_TAG: begin
            if (acc_new[2:0] != WireVarint && acc_new[2:0] != WireLength) begin
              res_valid = 1'b1;
              res_kind  = KIND_WIRE;
              res_fnum  = acc_new[ValueWidth-1:3];
              halted_d  = 1'b1;
            end else if (acc_new[ValueWidth-1:3] == '0) begin
              // Field number zero marks the end of the message.
              halted_d = 1'b1;
            end else begin
              field_d = acc_new[ValueWidth-1:3];
              phase_d = (acc_new[2:0] == WireVarint) ? PH_VALUE : PH_LENGTH;
            end
          end
          PH_VALUE: begin
            res_valid = 1'b1;
            res_kind  = KIND_VARINT;
            res_fnum  = field_q;
            res_value = acc_new;
            phase_d   = PH_TAG;
          end
          PH_LENGTH: begin
            if ((acc_new & ~LenMask) != '0) begin
              res_valid = 1'b1;
              res_kind  = KIND_TRUNC;
              res_fnum  = field_q;
              halted_d  = 1'b1;
            end else if (acc_new == '0) begin
              res_valid = 1'b1;
              res_kind  = KIND_EMPTY;
              res_fnum  = field_q;
              phase_d   = PH_TAG;
            end else begin
              rem_d   = acc_new[LengthBits-1:0];
              phase_d = PH_PAYLOAD;
            end
          end
          default: begin
            phase_d = PH_TAG;
          end
        endcase
      end
    end

    // The last byte always yields an item and returns all state to reset.
    if (item_i.last) begin
      if (!halted_d && (phase_d != PH_TAG || cnt_d != '0)) begin
        res_kind  = KIND_TRUNC;
        res_fnum  = (phase_d == PH_TAG) ? '0 : field_d;
        res_value = '0;
        res_plast = 1'b0;
      end else if (!res_valid) begin
        res_kind  = KIND_NONE;
        res_fnum  = '0;
        res_value = '0;
        res_plast = 1'b0;
      end
      res_valid = 1'b1;
      res_end   = 1'b1;
      phase_d   = PH_TAG;
      cnt_d     = '0;
      acc_d     = '0;
      field_d   = '0;
      rem_d     = '0;
      halted_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_TAG;
      cnt_q       <= '0;
      acc_q       <= '0;
      field_q     <= '0;
      rem_q       <= '0;
      halted_q    <= 1'b0;
      out_valid_q <= 1'b0;
      kind_q      <= KIND_NONE;
      fnum_q      <= '0;
      value_q     <= '0;
      plast_q     <= 1'b0;
      end_q       <= 1'b0;
    end else if (pop) begin
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      acc_q       <= acc_d;
      field_q     <= field_d;
      rem_q       <= rem_d;
      halted_q    <= halted_d;
      out_valid_q <= res_valid;
      kind_q      <= res_kind;
      fnum_q      <= res_fnum;
      value_q     <= res_value;
      plast_q     <= res_plast;
      end_q       <= res_end;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = kind_q;
  assign field_number_o = fnum_q;
  assign field_value_o  = value_q;
  assign payload_last_o = plast_q;
  assign message_end_o  = end_q;

endmodule

@@ src/pfd_checker.sv @@
// Port-level checker for the protobuf field decoder, bound to the top level.
// Depends on pfd_pkg and protobuf_field_decoder_assert.svh.
`include "protobuf_field_decoder_assert.svh"

module pfd_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic [2:0]                     kind_o,
  input logic [pfd_pkg::FieldWidth-1:0] field_number_o,
  input logic [pfd_pkg::ValueWidth-1:0] field_value_o,
  input logic                           payload_last_o,
  input logic                           message_end_o
);
  import pfd_pkg::*;

  `PFD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(kind_o) && $stable(field_number_o) && $stable(field_value_o) && $stable(message_end_o))
  `PFD_ASSERT_IMPL(a_none_only_at_end, clk_i, rst_ni, out_valid_o && kind_o == KIND_NONE, message_end_o)
  `PFD_ASSERT_IMPL(a_plast_on_byte, clk_i, rst_ni, out_valid_o && payload_last_o, kind_o == KIND_BYTE)
  `PFD_ASSERT_IMPL(a_value_zero, clk_i, rst_ni, out_valid_o && kind_o != KIND_VARINT && kind_o != KIND_BYTE, field_value_o == '0)
  `PFD_ASSERT_IMPL(a_byte_narrow, clk_i, rst_ni, out_valid_o && kind_o == KIND_BYTE, field_value_o[63:8] == '0)

endmodule

bind protobuf_field_decoder pfd_checker u_pfd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .kind_o         (kind_o),
  .field_number_o (field_number_o),
  .field_value_o  (field_value_o),
  .payload_last_o (payload_last_o),
  .message_end_o  (message_end_o)
);

@@ tb/testbench.sv @@
// Self-checking testbench for protobuf_field_decoder: directed messages, then random
// byte streams with random stalls on both channels, checked against an in-bench decoder.
// Depends on pfd_pkg and the protobuf_field_decoder RTL.
`timescale 1ns / 1ps

module testbench;
  import pfd_pkg::*;

  localparam int unsigned LengthBits     = pfd_pkg::LengthBitsDefault;
  localparam int unsigned MaxVarintBytes = pfd_pkg::MaxVarintBytesDefault;
  localparam int          StallLimit     = 1000;
  localparam int          DrainCycles    = 16;

  typedef enum logic [1:0] {
    PARSE_TAG,
    PARSE_VALUE,
    PARSE_LENGTH,
    PARSE_PAYLOAD
  } parse_phase_e;

  typedef struct packed {
    kind_e                 kind;
    logic [FieldWidth-1:0] field_number;
    logic [ValueWidth-1:0] field_value;
    logic                  payload_last;
    logic                  message_end;
  } decoded_t;

  logic                  clk          = 1'b0;
  logic                  rst_n        = 1'b0;
  logic [7:0]            in_byte      = 8'd0;
  logic                  in_last      = 1'b0;
  logic                  in_valid     = 1'b0;
  logic                  in_ready;
  logic [2:0]            kind;
  logic [FieldWidth-1:0] field_number;
  logic [ValueWidth-1:0] field_value;
  logic                  payload_last;
  logic                  message_end;
  logic                  out_valid;
  logic                  out_ready    = 1'b0;

  int send_idle_pct   = 20;
  int recv_idle_pct   = 62;
  int mismatch_count  = 0;
  int stall_cycles    = 0;

  decoded_t   decoded_queue[$];
  logic [7:0] msg_bytes[$];

  // Decoder state mirrored by the predictor.
  parse_phase_e          phase_q;
  int                    varint_count;
  logic [63:0]           varint_acc;
  logic [FieldWidth-1:0] open_field;
  logic [LengthBits-1:0] payload_left;
  bit                    discarding;

  protobuf_field_decoder dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_byte_i      (in_byte),
    .last_byte_i    (in_last),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .kind_o         (kind),
    .field_number_o (field_number),
    .field_value_o  (field_value),
    .payload_last_o (payload_last),
    .message_end_o  (message_end),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready)
  );

  always #5 clk = ~clk;

  function automatic void clear_decoder_state();
    phase_q      = PARSE_TAG;
    varint_count = 0;
    varint_acc   = '0;
    open_field   = '0;
    payload_left = '0;
    discarding   = 1'b0;
  endfunction

  // Works out the result, if any, that one accepted byte causes.
  function automatic void decode_byte(logic [7:0] b, logic last);
    decoded_t    res;
    logic [63:0] v;
    bit          produced;
    int          shift;
    res      = '0;
    res.kind = KIND_NONE;
    produced = 1'b0;
    if (!discarding) begin
      if (phase_q == PARSE_PAYLOAD) begin
        payload_left       = payload_left - 1'b1;
        res.kind           = KIND_BYTE;
        res.field_number   = open_field;
        res.field_value    = {56'd0, b};
        res.payload_last   = (payload_left == 0);
        produced           = 1'b1;
        if (payload_left == 0) phase_q = PARSE_TAG;
      end else begin
        shift = 7 * varint_count;
        // Value bits past bit 63 are dropped.
        if (shift < 64) varint_acc |= {57'd0, b[6:0]} << shift;
        if (!b[7]) begin
          varint_count = 0;
          v            = varint_acc;
          varint_acc   = '0;
          case (phase_q)
            PARSE_TAG: begin
              if (v[2:0] != WireVarint && v[2:0] != WireLength) begin
                res.kind         = KIND_WIRE;
                res.field_number = v[63:3];
                produced         = 1'b1;
                discarding       = 1'b1;
              end else if (v[63:3] == 0) begin
                discarding = 1'b1;
              end else begin
                open_field = v[63:3];
                phase_q    = (v[2:0] == WireVarint) ? PARSE_VALUE : PARSE_LENGTH;
              end
            end
            PARSE_VALUE: begin
              res.kind         = KIND_VARINT;
              res.field_number = open_field;
              res.field_value  = v;
              produced         = 1'b1;
              phase_q          = PARSE_TAG;
            end
            default: begin
              if ((v >> LengthBits) != 0) begin
                res.kind         = KIND_TRUNC;
                res.field_number = open_field;
                produced         = 1'b1;
                discarding       = 1'b1;
              end else if (v == 0) begin
                res.kind         = KIND_EMPTY;
                res.field_number = open_field;
                produced         = 1'b1;
                phase_q          = PARSE_TAG;
              end else begin
                payload_left = v[LengthBits-1:0];
                phase_q      = PARSE_PAYLOAD;
              end
            end
          endcase
        end else if (varint_count + 1 >= MaxVarintBytes) begin
          res.kind         = KIND_TRUNC;
          res.field_number = (phase_q == PARSE_TAG) ? '0 : open_field;
          produced         = 1'b1;
          discarding       = 1'b1;
        end else begin
          varint_count++;
        end
      end
    end
    if (last) begin
      // A field left open by the last byte replaces whatever that byte gave.
      if (!discarding && (phase_q != PARSE_TAG || varint_count != 0)) begin
        res              = '0;
        res.kind         = KIND_TRUNC;
        res.field_number = (phase_q == PARSE_TAG) ? '0 : open_field;
      end
      res.message_end = 1'b1;
      produced        = 1'b1;
      clear_decoder_state();
    end
    if (produced) decoded_queue = {decoded_queue, res};
  endfunction

  function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    end
  endfunction

  // Stimulus building: each helper appends to msg_bytes.
  function automatic void add_byte(logic [7:0] b);
    msg_bytes = {msg_bytes, b};
  endfunction

  function automatic void push_junk(int n);
    repeat (n) add_byte(8'($urandom_range(255)));
  endfunction

  function automatic void push_varint(logic [63:0] v, int pad);
    int          len;
    int          total;
    logic [63:0] part;
    len = 1;
    while (len < MaxVarintBytes && (v >> (7 * len)) != 0) len++;
    total = len + pad;
    if (total > MaxVarintBytes) total = MaxVarintBytes;
    for (int i = 0; i < total; i++) begin
      part = v >> (7 * i);
      add_byte({(i < total - 1) ? 1'b1 : 1'b0, part[6:0]});
    end
  endfunction

  function automatic void push_tag(logic [FieldWidth-1:0] fnum, logic [2:0] wt, int pad);
    push_varint({fnum, wt}, pad);
  endfunction

  function automatic int random_pad();
    return ($urandom_range(99) < 20) ? $urandom_range(1, 3) : 0;
  endfunction

  function automatic logic [FieldWidth-1:0] random_field_number();
    int          sel;
    logic [63:0] r;
    sel = $urandom_range(99);
    r   = {$urandom, $urandom};
    if (sel < 60)      r = 64'($urandom_range(1, 31));
    else if (sel < 80) r = 64'($urandom_range(1, 65535));
    else if (sel < 95) r = 64'(r[FieldWidth-1:0]);
    else               r = '1;
    if (r[FieldWidth-1:0] == 0) r = 64'd1;
    return r[FieldWidth-1:0];
  endfunction

  // Mostly well-formed messages with random content; some noise, some cut short.
  function automatic void build_message();
    int          sel;
    int          n;
    int          cut;
    logic [63:0] big;
    logic [2:0]  wt;
    msg_bytes.delete();
    if ($urandom_range(99) < 8) begin
      push_junk($urandom_range(1, 8));
      return;
    end
    repeat ($urandom_range(1, 5)) begin
      sel = $urandom_range(99);
      if (sel < 35) begin
        push_tag(random_field_number(), WireVarint, random_pad());
        n = $urandom_range(99);
        if (n < 5) begin
          push_varint('1, 0);
        end else if (n < 55) begin
          push_varint({$urandom, $urandom} >> $urandom_range(0, 63), random_pad());
        end else begin
          // Raw groups, so high bits of the tenth byte also get exercised.
          n = $urandom_range(1, MaxVarintBytes);
          for (int i = 0; i < n; i++)
            add_byte({(i < n - 1) ? 1'b1 : 1'b0, 7'($urandom_range(127))});
        end
      end else if (sel < 70) begin
        n = ($urandom_range(99) < 85) ? $urandom_range(0, 6) : $urandom_range(7, 40);
        push_tag(random_field_number(), WireLength, random_pad());
        push_varint(64'(n), random_pad());
        push_junk(n);
      end else if (sel < 78) begin
        do wt = 3'($urandom_range(7)); while (wt == WireVarint || wt == WireLength);
        push_tag(random_field_number(), wt, random_pad());
        push_junk($urandom_range(0, 3));
      end else if (sel < 84) begin
        push_tag('0, $urandom_range(1) ? WireLength : WireVarint, random_pad());
        push_junk($urandom_range(0, 3));
      end else if (sel < 90) begin
        // Overlong varint, either in the tag or in the value.
        if ($urandom_range(1)) push_tag(random_field_number(), WireVarint, 0);
        repeat (MaxVarintBytes) add_byte({1'b1, 7'($urandom_range(127))});
        push_junk($urandom_range(0, 2));
      end else if (sel < 95) begin
        big             = {$urandom, $urandom} >> $urandom_range(0, 31);
        big[LengthBits] = 1'b1;
        push_tag(random_field_number(), WireLength, random_pad());
        push_varint(big, 0);
        push_junk($urandom_range(0, 3));
      end else begin
        // Huge but legal length: the message runs out inside the payload.
        big = {32'd0, $urandom} | 64'h8000_0000;
        if ($urandom_range(1)) big = {32'd0, {LengthBits{1'b1}}};
        push_tag(random_field_number(), WireLength, random_pad());
        push_varint(big, random_pad());
        push_junk($urandom_range(1, 4));
      end
    end
    if ($urandom_range(99) < 15) begin
      cut       = int'($urandom_range(1, msg_bytes.size()));
      msg_bytes = msg_bytes[0:cut-1];
    end
  endfunction

  task automatic send_byte(logic [7:0] b, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= last;
    do @(posedge clk); while (in_ready !== 1'b1);
    decode_byte(b, last);
  endtask

  task automatic send_message();
    foreach (msg_bytes[i]) send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
  endtask

  task automatic test_varint_fields();
    // Zero value, a two-byte value finished by the last byte, then a value cut short.
    msg_bytes = '{8'h08, 8'h00, 8'h08, 8'h96, 8'h01};
    send_message();
    msg_bytes = '{8'h08, 8'h80};
    send_message();
  endtask

  task automatic test_length_fields();
    // Two-byte payload, an empty field, then a payload cut short by the last byte.
    msg_bytes = '{8'h12, 8'h02, 8'h00, 8'hFF, 8'h1A, 8'h00, 8'h0A, 8'h03, 8'h41};
    send_message();
  endtask

  task automatic test_error_cases();
    // Bad wire type, after which bytes are discarded up to the last one.
    msg_bytes = '{8'h0B, 8'h55, 8'h01};
    send_message();
    // End marker on the last byte.
    msg_bytes = '{8'h00};
    send_message();
    // Message ends inside a tag.
    msg_bytes = '{8'h80};
    send_message();
    // Length of exactly two to the 32nd.
    msg_bytes = '{8'h12, 8'h80, 8'h80, 8'h80, 8'h80, 8'h10, 8'h00};
    send_message();
  endtask

  task automatic test_random_stream(int sender_pct, int receiver_pct, int byte_target);
    int sent;
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    sent          = 0;
    while (sent < byte_target) begin
      build_message();
      sent += msg_bytes.size();
      send_message();
    end
  endtask

  always @(posedge clk) begin : result_check
    decoded_t want;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (decoded_queue.size() == 0) begin
        mismatch_count++;
        $display("%0t: result expected none actual kind %0h field %0h value %0h end %0b",
                 $time, kind, field_number, field_value, message_end);
      end else begin
        want = decoded_queue.pop_front();
        compare_field("kind", 64'(want.kind), 64'(kind));
        compare_field("field_number", 64'(want.field_number), 64'(field_number));
        compare_field("field_value", want.field_value, field_value);
        compare_field("payload_last", 64'(want.payload_last), 64'(payload_last));
        compare_field("message_end", 64'(want.message_end), 64'(message_end));
      end
    end
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= StallLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    clear_decoder_state();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_varint_fields();
    test_length_fields();
    test_error_cases();
    test_random_stream(20, 62, 400);
    test_random_stream(62, 20, 400);
    test_random_stream(0, 0, 400);
    in_valid <= 1'b0;
    while (decoded_queue.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatch_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+src
src/pfd_pkg.sv
src/pfd_front.sv
src/pfd_queue.sv
src/pfd_back.sv
src/protobuf_field_decoder.sv
src/pfd_checker.sv
tb/testbench.sv
